// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the decimal converter.
// Clock clk and active-low reset rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== src/itda_pkg.sv =====
// Types and constants for the integer to decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int VALUE_W    = 31;
    localparam int MIN_W      = 5;
    localparam int CHAR_W     = 6;
    localparam int LEN_W      = 5;
    localparam int NATURAL_MAX = 10;
    localparam int ND_W       = $clog2(NATURAL_MAX + 1);
    localparam int RI_W       = $clog2(NATURAL_MAX);
    localparam int Q_W        = 28;
    localparam int RECIP_SH   = 35;

    // ceil(2^35 / 10): exact floor(v / 10) for any 32-bit v
    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_EMIT
    } state_t;

endpackage

// ===== src/int_to_decimal_ascii.sv =====
// Integer to decimal ASCII converter: sequencer, reciprocal multiplier, digit store.
// Depends on itda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts a non-negative 31-bit value into decimal ASCII digits, most
// significant first, one output transaction per digit, padded with leading
// zeros up to min_digits (capped at MAX_DIGITS). is_last marks the final digit;
// total_length (low 5 bits of the count) rides on every digit. One item at a
// time: after the input transaction each natural digit takes a multiply step on
// the shared reciprocal multiplier, then a remainder step (1 to 10 natural
// digits), then one digit leaves per cycle while out_ready is high. The last
// digit may sit in the output register while the next item is already being
// converted.
module int_to_decimal_ascii
    import itda_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  value,
    input  logic [MIN_W-1:0]    min_digits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   digit_char,
    output logic                is_last,
    output logic [LEN_W-1:0]    total_length
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [ND_W-1:0]     nd_reg, nd_next;
    logic [CW-1:0]       want_reg, want_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          rev_reg [NATURAL_MAX];
    logic [CHAR_W-1:0]   digit_char_reg;
    logic                is_last_reg;
    logic [LEN_W-1:0]    total_length_reg;

    logic [63:0]         prod;
    logic [VALUE_W-1:0]  q_times10;
    logic [VALUE_W-1:0]  rem_wide;
    logic [3:0]          rem;
    logic [ND_W-1:0]     nd_inc;
    logic [CW-1:0]       total_c;
    logic                load;
    logic [3:0]          emit_digit;
    logic [CW-1:0]       want_in;

    assign prod      = {1'b0, val_reg} * RECIP;
    assign q_times10 = {q_reg, 3'b000} + VALUE_W'({q_reg, 1'b0});
    assign rem_wide  = val_reg - q_times10;
    assign rem       = rem_wide[3:0];
    assign nd_inc    = nd_reg + 1'b1;
    assign total_c   = (want_reg > CW'(nd_inc)) ? want_reg : CW'(nd_inc);
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign want_in   = (int'(min_digits) > MAX_DIGITS) ? CW'(MAX_DIGITS) : CW'(min_digits);
    // positions above the natural length are pad zeros
    assign emit_digit = (idx_reg < CW'(nd_reg)) ? rev_reg[idx_reg[RI_W-1:0]] : 4'd0;

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        q_next         = q_reg;
        nd_next        = nd_reg;
        want_next      = want_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next   = value;
                    want_next  = want_in;
                    nd_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                q_next     = prod[RECIP_SH + Q_W - 1:RECIP_SH];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                val_next = VALUE_W'(q_reg);
                nd_next  = nd_inc;
                if (q_reg == '0)
                begin
                    total_next = total_c;
                    idx_next   = total_c - 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nd_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nd_reg        <= nd_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        q_reg     <= q_next;
        want_reg  <= want_next;
        total_reg <= total_next;
        if (state_reg == ST_REM)
            rev_reg[nd_reg[RI_W-1:0]] <= rem;
        if (load)
        begin
            digit_char_reg   <= ASCII_ZERO + CHAR_W'(emit_digit);
            is_last_reg      <= (idx_reg == '0);
            total_length_reg <= LEN_W'(total_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_char   = digit_char_reg;
    assign is_last      = is_last_reg;
    assign total_length = total_length_reg;

    `ASSERT_CLK(a_accept_starts, (in_valid && in_ready) |=> (state_reg == ST_MUL), "accepted item did not start conversion")
    `ASSERT_CLK(a_last_to_idle, (load && idx_reg == '0) |=> (state_reg == ST_IDLE), "sequencer did not return to idle after last digit")
    `ASSERT_NEVER(a_nd_range, (nd_reg > ND_W'(NATURAL_MAX)), "natural digit count overran")
    `ASSERT_CLK(a_idx_range, (state_reg == ST_EMIT) |-> (idx_reg < total_reg), "emit index beyond total length")
    `ASSERT_NEVER(a_digit_range, (out_valid && (digit_char < 6'd48 || digit_char > 6'd57)), "digit outside ASCII 0 to 9")

endmodule
